// ----- rtl/timeout_slot_table_assert.svh -----
// Assertion macros used by the timer slot table engine.
`ifndef TIMEOUT_SLOT_TABLE_ASSERT_SVH
`define TIMEOUT_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("timer slot table: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("timer slot table: next-cycle check failed");

`endif

// ----- rtl/tst_pkg.sv -----
// Shared types, constants and helpers of the timer slot table.
`timescale 1ns / 1ps

package tst_pkg;

  localparam logic [21:0] MAX_SECONDS = 22'd2147483;
  localparam logic [30:0] MAX_MILLIS  = 31'h7FFF_FFFF;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  typedef enum logic [1:0] {
    OP_ADD_S  = 2'd0,
    OP_ADD_MS = 2'd1,
    OP_DELETE = 2'd2,
    OP_CHECK  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_REJECTED  = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DELETED   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FIRED     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_REJECT,
    CMD_DELETE,
    CMD_CHECK
  } cmd_e;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    cmd_e        kind;
    logic [31:0] now_ms;
    logic [30:0] ms;
    logic        periodic;
    logic        clamped;
    logic [3:0]  idx;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot_id;
    logic       fired;
    logic       clamped;
    logic       last;
  } res_t;

  // Deadline from the clock and a delay; zero is reserved, so bump it to one.
  function automatic logic [31:0] make_deadline(logic [31:0] now_ms, logic [31:0] delay);
    logic [31:0] sum;
    sum = now_ms + delay;
    return (sum == 32'd0) ? 32'd1 : sum;
  endfunction

endpackage

// ----- rtl/timeout_slot_table.sv -----
// Top level of the timer slot table: stream ports, front end, queue and engine.
`timescale 1ns / 1ps

// Timer slot table with SLOTS entries against a 32-bit millisecond clock that
// arrives with each request. A front end classifies each request (range check,
// clamp, seconds to milliseconds) into a two-entry queue; the engine behind it
// runs one request at a time. An add walks the in-use bits for the lowest free
// slot, and a check reads one slot per cycle through the read port of the
// deadline and period RAMs, stalling while a result waits for the full result
// register. A result of any request waits while the result register is still
// full. The in-use bits are flip-flops cleared by reset, so no clearing pass
// runs after reset. A check holds back each fired slot until the next one is
// found, so tlast marks the final result exactly.
module timeout_slot_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[31:0], delay_value[63:32], periodic[64], slot_index[68:65], zero fill
  input  logic [71:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // slot_id[3:0], fired_valid[4], delay_clamped[5], zero fill
  output logic [7:0]  m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  tst_pkg::cmd_t front_cmd;
  tst_pkg::cmd_t queue_cmd;
  tst_pkg::res_t res;
  logic          push;
  logic          queue_full;
  logic          queue_valid;
  logic          pop;

  tst_front u_front (
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .data_i      (s_axis_tdata),
    .kind_i      (s_axis_tuser),
    .queue_full_i(queue_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tst_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_cmd),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(queue_valid),
    .data_o (queue_cmd)
  );

  tst_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {2'b00, res.clamped, res.fired, res.slot_id};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

// ----- rtl/tst_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while the reader stalls
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/tst_front.sv -----
// Front end: unpack a request, range-check and clamp the delay, classify it.
`timescale 1ns / 1ps

module tst_front (
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [71:0]   data_i,
  input  logic [1:0]    kind_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output tst_pkg::cmd_t cmd_o
);

  logic [31:0] now_ms;
  logic [31:0] delay;
  logic        periodic;
  logic [3:0]  slot_index;
  logic [21:0] secs;
  logic        sec_clamp;
  logic [31:0] sec_ms;

  assign now_ms     = data_i[31:0];
  assign delay      = data_i[63:32];
  assign periodic   = data_i[64];
  assign slot_index = data_i[68:65];

  assign sec_clamp = (delay > {10'd0, tst_pkg::MAX_SECONDS});
  assign secs      = sec_clamp ? tst_pkg::MAX_SECONDS : delay[21:0];
  // at most 2147483000, so the result always fits in 31 bits
  assign sec_ms    = secs * tst_pkg::MS_PER_S;

  assign ready_o = !queue_full_i;
  assign push_o  = valid_i && !queue_full_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.now_ms   = now_ms;
    cmd_o.periodic = periodic;
    cmd_o.idx      = slot_index;
    unique case (tst_pkg::op_e'(kind_i))
      tst_pkg::OP_ADD_S: begin
        if (delay[31]) begin
          cmd_o.kind = tst_pkg::CMD_REJECT;
        end else begin
          cmd_o.kind    = tst_pkg::CMD_ADD;
          cmd_o.ms      = sec_ms[30:0];
          cmd_o.clamped = sec_clamp;
        end
      end
      tst_pkg::OP_ADD_MS: begin
        cmd_o.kind    = tst_pkg::CMD_ADD;
        cmd_o.ms      = delay[31] ? tst_pkg::MAX_MILLIS : delay[30:0];
        cmd_o.clamped = delay[31];
      end
      tst_pkg::OP_DELETE: cmd_o.kind = tst_pkg::CMD_DELETE;
      tst_pkg::OP_CHECK:  cmd_o.kind = tst_pkg::CMD_CHECK;
      default:            cmd_o.kind = tst_pkg::CMD_CHECK;
    endcase
  end

endmodule

// ----- rtl/tst_cmd_fifo.sv -----
// Two-entry request queue between the front end and the engine.
`timescale 1ns / 1ps

module tst_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tst_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tst_pkg::cmd_t data_o
);

  tst_pkg::cmd_t mem_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    count_q, count_d;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = do_push ? !wr_q : wr_q;
    rd_d    = do_pop ? !rd_q : rd_q;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/tst_back.sv -----
// Engine: executes requests against the slot table and registers each result.
`timescale 1ns / 1ps
`include "timeout_slot_table_assert.svh"

module tst_back #(
  parameter int SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tst_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output tst_pkg::res_t res_o
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_FIND,
    S_SCAN
  } state_e;

  state_e        state_q;
  tst_pkg::cmd_t cmd_q;
  logic [SLOTS-1:0] in_use_q;
  logic [IW-1:0] scan_q;
  logic [IW-1:0] rd_q;
  logic          rd_done_q;
  logic          ev_v_q;
  logic [IW-1:0] ev_slot_q;
  logic          pend_v_q;
  logic [IW-1:0] pend_slot_q;
  logic          out_v_q;
  tst_pkg::res_t out_q;

  logic          out_free;
  logic [IW-1:0] del_slot;
  logic          del_hit;
  logic          found;
  logic [31:0]   rd_deadline;
  logic [30:0]   rd_period;
  logic [31:0]   diff;
  logic          ev_hit;
  logic          finishing;
  logic          stall;
  logic          emit;
  tst_pkg::res_t emit_res;

  logic          dl_we;
  logic [IW-1:0] dl_waddr;
  logic [31:0]   dl_wdata;
  logic          pd_we;
  logic          rd_en;

  assign out_free = !out_v_q || res_ready_i;
  assign del_slot = IW'(cmd_q.idx);
  assign del_hit  = ({28'd0, cmd_q.idx} < 32'(SLOTS)) && in_use_q[del_slot];
  assign found    = !in_use_q[scan_q];

  // due when deadline - now, taken as signed, is at most zero
  assign diff      = rd_deadline - cmd_q.now_ms;
  assign ev_hit    = ev_v_q && in_use_q[ev_slot_q] && ((diff == 32'd0) || diff[31]);
  assign finishing = rd_done_q && !ev_v_q;

  always_comb begin
    emit     = 1'b0;
    stall    = 1'b0;
    emit_res = '0;
    unique case (state_q)
      S_ONE: begin
        emit         = out_free;
        emit_res.last = 1'b1;
        if (cmd_q.kind == tst_pkg::CMD_REJECT) begin
          emit_res.status = tst_pkg::STAT_REJECTED;
        end else begin
          emit_res.status  = del_hit ? tst_pkg::STAT_DELETED : tst_pkg::STAT_NOT_FOUND;
          emit_res.slot_id = cmd_q.idx;
        end
      end
      S_FIND: begin
        emit             = out_free && (found || (scan_q == LAST_SLOT));
        emit_res.status  = found ? tst_pkg::STAT_ADDED : tst_pkg::STAT_FULL;
        emit_res.slot_id = found ? 4'(scan_q) : 4'd0;
        emit_res.clamped = cmd_q.clamped;
        emit_res.last    = 1'b1;
      end
      S_SCAN: begin
        // a held hit goes out once the next hit or the end of the pass shows
        stall           = ((ev_hit && pend_v_q) || finishing) && !out_free;
        emit            = !stall && ((ev_hit && pend_v_q) || finishing);
        emit_res.status = tst_pkg::STAT_FIRED;
        if (pend_v_q) begin
          emit_res.slot_id = 4'(pend_slot_q);
          emit_res.fired   = 1'b1;
        end
        emit_res.last = finishing;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = scan_q;
    dl_wdata = tst_pkg::make_deadline(cmd_q.now_ms, {1'b0, cmd_q.ms});
    pd_we    = (state_q == S_FIND) && found && out_free;
    rd_en    = (state_q == S_SCAN) && !stall && !rd_done_q;
    if (pd_we) begin
      dl_we = 1'b1;
    end else if ((state_q == S_SCAN) && !stall && ev_hit && (rd_period != 31'd0)) begin
      dl_we    = 1'b1;
      dl_waddr = ev_slot_q;
      dl_wdata = tst_pkg::make_deadline(cmd_q.now_ms, {1'b0, rd_period});
    end
  end

  tst_ram #(
    .WIDTH(32),
    .DEPTH(SLOTS)
  ) u_deadline (
    .clk_i  (clk_i),
    .we_i   (dl_we),
    .waddr_i(dl_waddr),
    .wdata_i(dl_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_q),
    .rdata_o(rd_deadline)
  );

  tst_ram #(
    .WIDTH(31),
    .DEPTH(SLOTS)
  ) u_period (
    .clk_i  (clk_i),
    .we_i   (pd_we),
    .waddr_i(scan_q),
    .wdata_i(cmd_q.periodic ? cmd_q.ms : 31'd0),
    .re_i   (rd_en),
    .raddr_i(rd_q),
    .rdata_o(rd_period)
  );

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_use_q  <= '0;
      rd_done_q <= 1'b0;
      ev_v_q    <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (emit) begin
        out_v_q <= 1'b1;
        out_q   <= emit_res;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q     <= cmd_i;
            scan_q    <= '0;
            rd_q      <= '0;
            rd_done_q <= 1'b0;
            ev_v_q    <= 1'b0;
            pend_v_q  <= 1'b0;
            unique case (cmd_i.kind)
              tst_pkg::CMD_ADD:   state_q <= S_FIND;
              tst_pkg::CMD_CHECK: state_q <= S_SCAN;
              default:            state_q <= S_ONE;
            endcase
          end
        end
        S_ONE: begin
          if (emit) begin
            if ((cmd_q.kind == tst_pkg::CMD_DELETE) && del_hit) begin
              in_use_q[del_slot] <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        S_FIND: begin
          if (emit) begin
            if (found) begin
              in_use_q[scan_q] <= 1'b1;
            end
            state_q <= S_IDLE;
          end else if (!found && (scan_q != LAST_SLOT)) begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (!rd_done_q) begin
              rd_q <= rd_q + 1'b1;
              if (rd_q == LAST_SLOT) begin
                rd_done_q <= 1'b1;
              end
            end
            ev_v_q    <= !rd_done_q;
            ev_slot_q <= rd_q;
            if (ev_hit) begin
              pend_v_q    <= 1'b1;
              pend_slot_q <= ev_slot_q;
              // one-shot slots free on firing
              if (rd_period == 31'd0) begin
                in_use_q[ev_slot_q] <= 1'b0;
              end
            end
            if (finishing) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `TST_ASSERT_NEXT(a_scan_ends, clk_i, rst_ni,
                   (state_q == S_SCAN) && finishing && out_free, state_q == S_IDLE)
  `TST_ASSERT_NOW(a_eval_trails_read, clk_i, rst_ni,
                  (state_q == S_SCAN) && ev_v_q && !rd_done_q, rd_q == IW'(ev_slot_q + 1'b1))
  `TST_ASSERT_NOW(a_add_takes_free, clk_i, rst_ni,
                  dl_we && (state_q == S_FIND), !in_use_q[dl_waddr])
  `TST_ASSERT_NOW(a_fired_only_check, clk_i, rst_ni,
                  out_v_q && out_q.fired, out_q.status == tst_pkg::STAT_FIRED)

endmodule

// ----- bench/timeout_slot_table_test.sv -----
// Self-checking bench for the timer slot table: directed rows, random requests, result checks.
`timescale 1ns / 1ps

module timeout_slot_table_test;

  localparam int SLOTS         = 16;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 80;
  localparam int QUIET_ITEMS   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 4 * SLOTS + 8;

  typedef struct packed {
    tst_pkg::status_e status;
    logic [3:0]       slot;
    logic             fired;
    logic             clamped;
    logic             last;
  } result_t;

  typedef struct packed {
    tst_pkg::op_e op;
    logic [31:0]  now;
    logic [31:0]  val;
    logic         per;
    logic [3:0]   idx;
    bit           typed;
    result_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // Own copy of the slot state
  logic        slot_busy   [SLOTS];
  logic [31:0] slot_due    [SLOTS];
  logic [30:0] slot_reload [SLOTS];

  result_t step_results[$];
  result_t expected_results[$];

  int bad_fields   = 0;
  int items_sent   = 0;
  int stall_cycles = 0;
  bit quiet        = 1'b0;
  bit hold_off_req = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // nothing stored yet
    '{tst_pkg::OP_CHECK,  32'd0,          32'd0,          1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_FIRED, 4'd0, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_DELETE, 32'd0,          32'd0,          1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_NOT_FOUND, 4'd0, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_DELETE, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 4'd15, 1'b1,
      '{tst_pkg::STAT_NOT_FOUND, 4'd15, 1'b0, 1'b0, 1'b1}},
    // negative seconds
    '{tst_pkg::OP_ADD_S,  32'd0,          32'h8000_0000,  1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_REJECTED, 4'd0, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_ADD_S,  32'd0,          32'hFFFF_FFFF,  1'b1, 4'd0,  1'b1,
      '{tst_pkg::STAT_REJECTED, 4'd0, 1'b0, 1'b0, 1'b1}},
    // clamp edges in both units
    '{tst_pkg::OP_ADD_S,  32'd0,          32'd2147484,    1'b1, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd0, 1'b0, 1'b1, 1'b1}},
    '{tst_pkg::OP_ADD_S,  32'd0,          32'd2147483,    1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd1, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_ADD_MS, 32'd0,          32'hFFFF_FFFF,  1'b1, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd2, 1'b0, 1'b1, 1'b1}},
    '{tst_pkg::OP_ADD_MS, 32'd0,          32'h8000_0000,  1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd3, 1'b0, 1'b1, 1'b1}},
    '{tst_pkg::OP_ADD_MS, 32'd0,          32'h7FFF_FFFF,  1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd4, 1'b0, 1'b0, 1'b1}},
    // deadline wraps to zero and is bumped
    '{tst_pkg::OP_ADD_MS, 32'hFFFF_FFFF,  32'd1,          1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd5, 1'b0, 1'b0, 1'b1}},
    // periodic with zero delay acts as one-shot
    '{tst_pkg::OP_ADD_MS, 32'd10,         32'd0,          1'b1, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd6, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_ADD_MS, 32'd10,         32'd5,          1'b1, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd7, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_ADD_S,  32'd10,         32'd0,          1'b0, 4'd0,  1'b1,
      '{tst_pkg::STAT_ADDED, 4'd8, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_CHECK,  32'd10,         32'd0,          1'b0, 4'd0,  1'b0, '0},
    '{tst_pkg::OP_CHECK,  32'd15,         32'd0,          1'b1, 4'd0,  1'b0, '0},
    '{tst_pkg::OP_DELETE, 32'd15,         32'd0,          1'b0, 4'd7,  1'b1,
      '{tst_pkg::STAT_DELETED, 4'd7, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_DELETE, 32'd15,         32'd0,          1'b1, 4'd7,  1'b1,
      '{tst_pkg::STAT_NOT_FOUND, 4'd7, 1'b0, 1'b0, 1'b1}},
    '{tst_pkg::OP_CHECK,  32'd14,         32'd0,          1'b0, 4'd0,  1'b0, '0},
    '{tst_pkg::OP_CHECK,  32'h8000_0000,  32'hFFFF_FFFF,  1'b0, 4'd0,  1'b0, '0},
    '{tst_pkg::OP_CHECK,  32'hFFFF_FFFF,  32'd0,          1'b1, 4'd15, 1'b0, '0},
    '{tst_pkg::OP_DELETE, 32'hFFFF_FFFF,  32'd0,          1'b0, 4'd0,  1'b0, '0}
  };

  timeout_slot_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .m_axis_tlast (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] deadline_from(logic [31:0] now, logic [31:0] delay);
    logic [31:0] sum;
    sum = now + delay;
    return (sum == 32'd0) ? 32'd1 : sum;
  endfunction

  // Work out the results of one request into step_results and advance the slot state
  function automatic void predict_timer_results(tst_pkg::op_e op, logic [31:0] now,
                                                logic [31:0] val, logic per,
                                                logic [3:0] idx);
    logic [31:0] ms;
    logic [31:0] diff;
    logic        clamped;
    int          slot;
    int          fired_count;
    clamped = 1'b0;
    ms      = val;
    case (op)
      tst_pkg::OP_ADD_S, tst_pkg::OP_ADD_MS: begin
        if (op == tst_pkg::OP_ADD_S && val[31]) begin
          step_results.push_back('{tst_pkg::STAT_REJECTED, 4'd0, 1'b0, 1'b0, 1'b1});
          return;
        end
        if (op == tst_pkg::OP_ADD_S) begin
          if (val > 32'(tst_pkg::MAX_SECONDS)) begin
            ms      = 32'(tst_pkg::MAX_SECONDS);
            clamped = 1'b1;
          end
          ms = ms * 32'(tst_pkg::MS_PER_S);
        end
        if (ms > 32'(tst_pkg::MAX_MILLIS)) begin
          ms      = 32'(tst_pkg::MAX_MILLIS);
          clamped = 1'b1;
        end
        slot = -1;
        for (int k = 0; k < SLOTS; k++) begin
          if (slot < 0 && !slot_busy[k]) slot = k;
        end
        if (slot < 0) begin
          step_results.push_back('{tst_pkg::STAT_FULL, 4'd0, 1'b0, clamped, 1'b1});
        end else begin
          slot_busy[slot]   = 1'b1;
          slot_due[slot]    = deadline_from(now, ms);
          slot_reload[slot] = per ? ms[30:0] : 31'd0;
          step_results.push_back('{tst_pkg::STAT_ADDED, 4'(slot), 1'b0, clamped, 1'b1});
        end
      end
      tst_pkg::OP_DELETE: begin
        if (int'(idx) < SLOTS && slot_busy[idx]) begin
          slot_busy[idx] = 1'b0;
          step_results.push_back('{tst_pkg::STAT_DELETED, idx, 1'b0, 1'b0, 1'b1});
        end else begin
          step_results.push_back('{tst_pkg::STAT_NOT_FOUND, idx, 1'b0, 1'b0, 1'b1});
        end
      end
      default: begin
        fired_count = 0;
        for (int k = 0; k < SLOTS; k++) begin
          if (slot_busy[k]) begin
            diff = slot_due[k] - now;
            // due when the wrap-safe difference is zero or negative
            if (diff == 32'd0 || diff[31]) begin
              if (slot_reload[k] != 31'd0) slot_due[k] = deadline_from(now, {1'b0, slot_reload[k]});
              else slot_busy[k] = 1'b0;
              step_results.push_back('{tst_pkg::STAT_FIRED, 4'(k), 1'b1, 1'b0, 1'b0});
              fired_count++;
            end
          end
        end
        if (fired_count == 0)
          step_results.push_back('{tst_pkg::STAT_FIRED, 4'd0, 1'b0, 1'b0, 1'b1});
        else step_results[step_results.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_delay(tst_pkg::op_e op);
    case ($urandom_range(0, 7))
      0: begin
        return $urandom();
      end
      1: begin
        return (op == tst_pkg::OP_ADD_S) ? 32'd2147482 + $urandom_range(0, 2)
                                         : 32'h7FFF_FFFE + $urandom_range(0, 2);
      end
      default: begin
        return (op == tst_pkg::OP_ADD_S) ? $urandom_range(0, 1) : $urandom_range(0, 100);
      end
    endcase
  endfunction

  task automatic report_bad_field(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: bad %s: got %0d, wanted %0d", $realtime, what, got, want);
    bad_fields++;
  endtask

  // Offer one request, wait for it to be taken, then queue what it should produce
  task automatic offer_request(tst_pkg::op_e op, logic [31:0] now, logic [31:0] val,
                               logic per, logic [3:0] idx, bit typed, result_t want);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tdata  <= {3'b000, idx, per, val, now};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    step_results.delete();
    predict_timer_results(op, now, val, per, idx);
    if (typed) expected_results.push_back(want);
    else foreach (step_results[k]) expected_results.push_back(step_results[k]);
    items_sent++;
  endtask

  // Receiver: random back-pressure, one long hold-off on request, none when quiet
  initial begin : result_sink
    int hold_left;
    int gap_left;
    hold_left = 0;
    gap_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else if (gap_left > 0) begin
        m_tready <= 1'b0;
        gap_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_bad_field("result with nothing pending, status", 32'(m_tuser), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status)
          report_bad_field("status", 32'(m_tuser), 32'(want.status));
        if (m_tdata[3:0] !== want.slot)
          report_bad_field("slot_id", 32'(m_tdata[3:0]), 32'(want.slot));
        if (m_tdata[4] !== want.fired)
          report_bad_field("fired_valid", 32'(m_tdata[4]), 32'(want.fired));
        if (m_tdata[5] !== want.clamped)
          report_bad_field("delay_clamped", 32'(m_tdata[5]), 32'(want.clamped));
        if (m_tlast !== want.last)
          report_bad_field("tlast", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]  now_cur;
    logic [31:0]  dly;
    tst_pkg::op_e op;
    int           free_slots;
    int           burst;
    bit           hold_done;
    bit           pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    foreach (slot_busy[k]) slot_busy[k] = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      offer_request(directed_rows[r].op, directed_rows[r].now, directed_rows[r].val,
                    directed_rows[r].per, directed_rows[r].idx, directed_rows[r].typed,
                    directed_rows[r].want);

    now_cur = $urandom();
    while (items_sent - DIRECTED_ROWS < RANDOM_ITEMS) begin
      quiet = (items_sent - DIRECTED_ROWS >= RANDOM_ITEMS - QUIET_ITEMS);
      if (!hold_done && items_sent - DIRECTED_ROWS >= 30) begin
        // keep offering while the receiver holds off, so the input backs up
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && items_sent - DIRECTED_ROWS >= 60) begin
        pause_done = 1'b1;
        // drop the request line first so the last request is not taken twice
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          now_cur += $urandom_range(0, 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              op = $urandom_range(0, 1) ? tst_pkg::OP_ADD_MS : tst_pkg::OP_ADD_S;
            end
            4, 5, 6: begin
              op = tst_pkg::OP_CHECK;
            end
            default: begin
              op = tst_pkg::OP_DELETE;
            end
          endcase
          offer_request(op, now_cur, pick_delay(op), 1'($urandom_range(0, 1)),
                        4'($urandom_range(0, 15)), 1'b0, '0);
        end
        6, 7: begin
          // a few short timers, then advance the clock and look for expiries
          burst = $urandom_range(1, 4);
          repeat (burst) begin
            op = $urandom_range(0, 3) ? tst_pkg::OP_ADD_MS : tst_pkg::OP_ADD_S;
            offer_request(op, now_cur, pick_delay(op), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 1'b0, '0);
            now_cur += $urandom_range(0, 10);
          end
          now_cur += $urandom_range(0, 120);
          offer_request(tst_pkg::OP_CHECK, now_cur, $urandom(), 1'($urandom_range(0, 1)),
                        4'($urandom_range(0, 15)), 1'b0, '0);
        end
        8: begin
          // fill the table and push past it, then free a few slots
          free_slots = 0;
          foreach (slot_busy[k]) if (!slot_busy[k]) free_slots++;
          repeat (free_slots + $urandom_range(1, 2)) begin
            op = $urandom_range(0, 1) ? tst_pkg::OP_ADD_MS : tst_pkg::OP_ADD_S;
            if (op == tst_pkg::OP_ADD_MS && $urandom_range(0, 3) == 0) dly = 32'hFFFF_FFFF;
            else if (op == tst_pkg::OP_ADD_S) dly = $urandom_range(1, 60);
            else dly = $urandom_range(1000, 60000);
            offer_request(op, now_cur, dly, 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 1'b0, '0);
          end
          repeat ($urandom_range(1, 4))
            offer_request(tst_pkg::OP_DELETE, now_cur, $urandom(), 1'($urandom_range(0, 1)),
                          4'($urandom_range(0, 15)), 1'b0, '0);
        end
        default: begin
          // noise: any request, any clock, sometimes a jump of the running clock
          if ($urandom_range(0, 1)) now_cur = $urandom();
          offer_request(tst_pkg::op_e'($urandom_range(0, 3)), $urandom(), $urandom(),
                        1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b0, '0);
        end
      endcase
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_fields == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tst_pkg.sv
rtl/tst_ram.sv
rtl/tst_front.sv
rtl/tst_cmd_fifo.sv
rtl/tst_back.sv
rtl/timeout_slot_table.sv
bench/timeout_slot_table_test.sv
